[hdl/kmmsa_pkg.sv]
// ----------------------------------------------------------------------------
// kmmsa_pkg
// types and constants shared by the keyed aggregator modules
// ----------------------------------------------------------------------------
package kmmsa_pkg;

  typedef struct packed {
    logic [63:0]        key_word;
    logic               key_last;
    logic [31:0]        add_count;
    logic signed [15:0] add_min;
    logic signed [15:0] add_max;
    logic signed [47:0] add_sum;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         entry_index;
    logic               is_new;
    logic               dropped;
    logic [31:0]        total_count;
    logic signed [15:0] min_tenths;
    logic signed [15:0] max_tenths;
    logic signed [47:0] sum_tenths;
  } out_item_t;

  // aggregate part of a finished record, queued from front to back
  typedef struct packed {
    logic [31:0]        cnt;
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    logic signed [47:0] sm;
  } agg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RD,
    ST_MERGE,
    ST_APPEND,
    ST_OUT
  } back_state_e;

  localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

endpackage

[hdl/keyed_min_max_sum_aggregator.sv]
// ----------------------------------------------------------------------------
// keyed_min_max_sum_aggregator
// string-keyed count, min, max and sum table with linear key search
// ----------------------------------------------------------------------------
// Key words are taken one per cycle into a staging buffer, save that a last word
// stalls while the queued record is not yet taken; a finished record waits in a
// one-deep queue while the back part searches. The search walks the key memory
// one word per cycle with a registered read, moving to the next entry on a
// mismatch until a full match or the last entry, then appends the key word by word,
// merges, or drops the record when the table is full, then registers the result
// and returns to idle. The tables are not cleared after reset: only used slots are read, tracked by a fill count.
module keyed_min_max_sum_aggregator #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WORDS   = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kmmsa_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kmmsa_pkg::out_item_t out_data_o
);
  import kmmsa_pkg::*;

  logic                       rec_valid, rec_take;
  logic [KEY_WORDS-1:0][63:0] rec_key;
  agg_t                       rec_agg;

  kmmsa_front #(.KEY_WORDS(KEY_WORDS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .rec_valid_o(rec_valid), .rec_take_i(rec_take),
    .rec_key_o(rec_key), .rec_agg_o(rec_agg)
  );

  kmmsa_back #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WORDS(KEY_WORDS)) u_back (
    .clk_i, .rst_ni,
    .rec_valid_i(rec_valid), .rec_take_o(rec_take),
    .rec_key_i(rec_key), .rec_agg_i(rec_agg),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

[hdl/kmmsa_front.sv]
// ----------------------------------------------------------------------------
// kmmsa_front
// collects key words into a staging buffer and hands a finished record over
// ----------------------------------------------------------------------------
module kmmsa_front #(
  parameter int KEY_WORDS = 13
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  kmmsa_pkg::in_item_t                    in_data_i,
  output logic                                   rec_valid_o,
  input  logic                                   rec_take_i,
  output logic [KEY_WORDS-1:0][63:0]             rec_key_o,
  output kmmsa_pkg::agg_t                        rec_agg_o
);
  import kmmsa_pkg::*;

  localparam int PosW = $clog2(KEY_WORDS + 1);

  logic [KEY_WORDS-1:0][63:0] buf_q, buf_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic                       full_q, full_d;
  logic [KEY_WORDS-1:0][63:0] key_q, key_d;
  agg_t                       agg_q, agg_d;
  logic                       acc;

  // one-record queue slot: words keep flowing while the back part searches,
  // only a second finished record waits
  assign in_stall_o  = full_q && !rec_take_i && in_data_i.key_last;
  assign acc         = in_valid_i && !in_stall_o;
  assign rec_valid_o = full_q;
  assign rec_key_o   = key_q;
  assign rec_agg_o   = agg_q;

  always_comb begin
    buf_d  = buf_q;
    pos_d  = pos_q;
    full_d = full_q && !rec_take_i;
    key_d  = key_q;
    agg_d  = agg_q;
    if (acc) begin
      if (pos_q < PosW'(KEY_WORDS)) begin
        buf_d[pos_q[PosW-1:0]] = in_data_i.key_word;
        pos_d = pos_q + PosW'(1);
      end
      if (in_data_i.key_last) begin
        key_d     = buf_d;
        agg_d.cnt = in_data_i.add_count;
        agg_d.mn  = in_data_i.add_min;
        agg_d.mx  = in_data_i.add_max;
        agg_d.sm  = in_data_i.add_sum;
        full_d    = 1'b1;
        buf_d     = '0;
        pos_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      pos_q  <= '0;
      full_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      pos_q  <= pos_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    agg_q <= agg_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && !rec_take_i |=> full_q && $stable(key_q))
    else $error("queued record lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.key_last |=> pos_q == '0)
    else $error("word position not cleared after record");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(KEY_WORDS))
    else $error("word position past key limit");

endmodule

[hdl/kmmsa_back.sv]
// ----------------------------------------------------------------------------
// kmmsa_back
// linear key search over the table, merge, append or drop, and result register
// ----------------------------------------------------------------------------
module kmmsa_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WORDS   = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rec_valid_i,
  output logic                       rec_take_o,
  input  logic [KEY_WORDS-1:0][63:0] rec_key_i,
  input  kmmsa_pkg::agg_t            rec_agg_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kmmsa_pkg::out_item_t       out_data_o
);
  import kmmsa_pkg::*;

  localparam int SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int WordW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KeyD  = TABLE_DEPTH * KEY_WORDS;
  localparam int KeyAW = (KeyD > 1) ? $clog2(KeyD) : 1;

  logic [63:0] key_mem [KeyD];
  logic [31:0] cnt_mem [TABLE_DEPTH];
  logic [15:0] mn_mem  [TABLE_DEPTH];
  logic [15:0] mx_mem  [TABLE_DEPTH];
  logic [47:0] sm_mem  [TABLE_DEPTH];

  back_state_e st_q, st_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [WordW-1:0] w_q, w_d;
  logic             eq_q, eq_d;
  logic             rd_pend_q, rd_pend_d;
  logic [KeyAW-1:0] kaddr_q, kaddr_d;
  logic [63:0]      krd_q;
  logic [31:0]      crd_q;
  logic signed [15:0] mnrd_q, mxrd_q;
  logic signed [47:0] smrd_q;
  out_item_t        res_q, res_d;
  logic             ov_q, ov_d;
  logic             kwr_en, awr_en, kwr_en_any;
  logic [KeyAW-1:0] kwr_addr;
  logic [32:0]      csum;
  logic signed [48:0] ssum;
  logic [31:0]      cnew;
  logic signed [47:0] snew;
  logic signed [15:0] mnnew, mxnew;

  // key compare walks one word per cycle through a registered memory read:
  // the next address is issued so its data lines up with kaddr_q
  always_ff @(posedge clk_i) begin
    if (kwr_en_any) key_mem[kwr_addr] <= rec_key_i[w_q];
    krd_q <= key_mem[kaddr_d];
  end

  always_ff @(posedge clk_i) begin
    if (awr_en) begin
      cnt_mem[slot_q] <= res_d.total_count;
      mn_mem[slot_q]  <= res_d.min_tenths;
      mx_mem[slot_q]  <= res_d.max_tenths;
      sm_mem[slot_q]  <= res_d.sum_tenths;
    end
    crd_q  <= cnt_mem[slot_q];
    mnrd_q <= mn_mem[slot_q];
    mxrd_q <= mx_mem[slot_q];
    smrd_q <= sm_mem[slot_q];
  end

  assign csum  = {1'b0, crd_q} + {1'b0, rec_agg_i.cnt};
  assign ssum  = {smrd_q[47], smrd_q} + {rec_agg_i.sm[47], rec_agg_i.sm};
  assign cnew  = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
  assign snew  = (ssum > 49'(SumMax)) ? SumMax :
                 (ssum < 49'(SumMin)) ? SumMin : ssum[47:0];
  assign mnnew = (rec_agg_i.mn < mnrd_q) ? rec_agg_i.mn : mnrd_q;
  assign mxnew = (rec_agg_i.mx > mxrd_q) ? rec_agg_i.mx : mxrd_q;

  assign kwr_addr   = KeyAW'(slot_q * KEY_WORDS) + KeyAW'(w_q);
  assign kwr_en_any = kwr_en;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (rec_valid_i) st_d = (used_q == '0) ? ST_APPEND : ST_CMP;
      ST_CMP: begin
        if (rd_pend_q && (!eq_q || krd_q != rec_key_i[w_q] ||
            w_q == WordW'(KEY_WORDS - 1))) begin
          if (eq_q && krd_q == rec_key_i[w_q]) st_d = ST_RD;
          else if (UsedW'(slot_q) + UsedW'(1) >= used_q) begin
            st_d = ST_APPEND;
          end
        end
      end
      ST_RD:     st_d = ST_MERGE;
      ST_MERGE:  st_d = ST_OUT;
      ST_APPEND: begin
        if (used_q >= UsedW'(TABLE_DEPTH) || w_q == WordW'(KEY_WORDS - 1)) begin
          st_d = ST_OUT;
        end
      end
      ST_OUT:    if (!ov_q) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    slot_d     = slot_q;
    w_d        = w_q;
    eq_d       = eq_q;
    rd_pend_d  = 1'b0;
    kaddr_d    = kaddr_q;
    used_d     = used_q;
    res_d      = res_q;
    ov_d       = ov_q && out_stall_i;
    kwr_en     = 1'b0;
    awr_en     = 1'b0;
    rec_take_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        slot_d  = '0;
        w_d     = '0;
        eq_d    = 1'b1;
        kaddr_d = '0;
        if (rec_valid_i && used_q != '0) rd_pend_d = 1'b1;
        if (rec_valid_i && used_q == '0) slot_d = '0;
      end
      ST_CMP: begin
        rd_pend_d = 1'b1;
        if (rd_pend_q) begin
          if (eq_q && krd_q == rec_key_i[w_q] && w_q == WordW'(KEY_WORDS - 1)) begin
            rd_pend_d = 1'b0;
          end else if (eq_q && krd_q == rec_key_i[w_q]) begin
            w_d     = w_q + WordW'(1);
            kaddr_d = kaddr_q + KeyAW'(1);
          end else begin
            // mismatch: skip to next slot, or to the free slot used_q when none is left
            w_d     = '0;
            eq_d    = 1'b1;
            kaddr_d = KeyAW'((slot_q + SlotW'(1)) * KEY_WORDS);
            if (UsedW'(slot_q) + UsedW'(1) >= used_q) begin
              rd_pend_d = 1'b0;
              slot_d    = SlotW'(used_q);
            end else begin
              slot_d = slot_q + SlotW'(1);
            end
          end
        end
      end
      ST_RD: ;
      ST_MERGE: begin
        res_d.entry_index = 10'(slot_q);
        res_d.is_new      = 1'b0;
        res_d.dropped     = 1'b0;
        res_d.total_count = cnew;
        res_d.min_tenths  = mnnew;
        res_d.max_tenths  = mxnew;
        res_d.sum_tenths  = snew;
        awr_en            = 1'b1;
        ov_d              = 1'b1;
        rec_take_o        = 1'b1;
      end
      ST_APPEND: begin
        if (used_q >= UsedW'(TABLE_DEPTH)) begin
          res_d      = '0;
          res_d.dropped = 1'b1;
          ov_d       = 1'b1;
          rec_take_o = 1'b1;
        end else begin
          kwr_en = 1'b1;
          w_d    = w_q + WordW'(1);
          if (w_q == WordW'(KEY_WORDS - 1)) begin
            res_d.entry_index = 10'(slot_q);
            res_d.is_new      = 1'b1;
            res_d.dropped     = 1'b0;
            res_d.total_count = rec_agg_i.cnt;
            res_d.min_tenths  = rec_agg_i.mn;
            res_d.max_tenths  = rec_agg_i.mx;
            res_d.sum_tenths  = rec_agg_i.sm;
            awr_en            = 1'b1;
            used_d            = used_q + UsedW'(1);
            ov_d              = 1'b1;
            rec_take_o        = 1'b1;
          end
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      used_q    <= '0;
      ov_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      slot_q    <= '0;
      w_q       <= '0;
      eq_q      <= 1'b1;
      kaddr_q   <= '0;
    end else begin
      st_q      <= st_d;
      used_q    <= used_d;
      ov_q      <= ov_d;
      rd_pend_q <= rd_pend_d;
      slot_q    <= slot_d;
      w_q       <= w_d;
      eq_q      <= eq_d;
      kaddr_q   <= kaddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TABLE_DEPTH))
    else $error("fill count past table depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_take_o |=> ov_q)
    else $error("record taken without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> $stable(res_q))
    else $error("stalled result changed");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the keyed aggregator against an in-bench table model: a directed
// list of records, random records over a small key pool, then a fill of the
// whole table followed by records that merge or must be dropped
// ----------------------------------------------------------------------------
module testbench;
  import kmmsa_pkg::*;

  localparam int TD = 1024;
  localparam int KW = 13;
  localparam int RAND_WORDS = 250;
  localparam int POOL = 24;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_item_t out_data_o;

  // typed-in expectation that travels with the current input transfer
  logic      row_typed = 1'b0;
  out_item_t row_exp = '0;

  bit quiet = 1'b0;

  keyed_min_max_sum_aggregator uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the aggregate table
  logic [KW-1:0][63:0] key_tab [TD];
  logic [31:0]         cnt_tab [TD];
  logic signed [15:0]  min_tab [TD];
  logic signed [15:0]  max_tab [TD];
  logic signed [47:0]  sum_tab [TD];
  int                  used = 0;
  logic [KW-1:0][63:0] kbuf = '0;
  int                  wpos = 0;

  out_item_t pending_totals[$];
  int mismatch_cnt = 0;
  int n_records = 0, n_new = 0, n_drop = 0, n_merge = 0, words_sent = 0;

  function automatic bit aggregate_word(input in_item_t it, output out_item_t r);
    logic [32:0]        c;
    logic signed [48:0] s;
    int                 slot;
    bit                 hit;
    r = '0;
    if (wpos < KW) begin
      kbuf[wpos] = it.key_word;
      wpos++;
    end
    if (!it.key_last) return 1'b0;
    hit = 1'b0;
    slot = 0;
    for (int i = 0; i < used; i++) begin
      if (!hit && key_tab[i] == kbuf) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      c = {1'b0, cnt_tab[slot]} + {1'b0, it.add_count};
      cnt_tab[slot] = c[32] ? 32'hFFFF_FFFF : c[31:0];
      s = {sum_tab[slot][47], sum_tab[slot]} + {it.add_sum[47], it.add_sum};
      // saturate when the 49-bit sum leaves the 48-bit range
      if (s[48] != s[47]) sum_tab[slot] = s[48] ? SumMin : SumMax;
      else sum_tab[slot] = s[47:0];
      if (it.add_min < min_tab[slot]) min_tab[slot] = it.add_min;
      if (it.add_max > max_tab[slot]) max_tab[slot] = it.add_max;
      r.entry_index = slot[9:0];
      r.total_count = cnt_tab[slot];
      r.min_tenths  = min_tab[slot];
      r.max_tenths  = max_tab[slot];
      r.sum_tenths  = sum_tab[slot];
    end else if (used < TD) begin
      key_tab[used] = kbuf;
      cnt_tab[used] = it.add_count;
      min_tab[used] = it.add_min;
      max_tab[used] = it.add_max;
      sum_tab[used] = it.add_sum;
      r.entry_index = used[9:0];
      r.is_new      = 1'b1;
      r.total_count = it.add_count;
      r.min_tenths  = it.add_min;
      r.max_tenths  = it.add_max;
      r.sum_tenths  = it.add_sum;
      used++;
    end else begin
      r.dropped = 1'b1;
    end
    kbuf = '0;
    wpos = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t r;
    out_item_t e;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        if (aggregate_word(in_data, r)) begin
          if (row_typed) r = row_exp;
          pending_totals.push_back(r);
          n_records++;
          if (r.dropped) n_drop++;
          else if (r.is_new) n_new++;
          else n_merge++;
        end
      end
      if (out_valid_o && !out_stall) begin
        if (pending_totals.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result transfer: %p", out_data_o);
        end else begin
          e = pending_totals.pop_front();
          if (out_data_o.entry_index !== e.entry_index || out_data_o.is_new !== e.is_new ||
              out_data_o.dropped !== e.dropped || out_data_o.total_count !== e.total_count ||
              out_data_o.min_tenths !== e.min_tenths ||
              out_data_o.max_tenths !== e.max_tenths ||
              out_data_o.sum_tenths !== e.sum_tenths) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: expected %p actual %p", e, out_data_o);
          end
        end
      end
    end
  end

  function automatic in_item_t mk(logic [63:0] w, logic l, logic [31:0] c,
                                  logic signed [15:0] mn, logic signed [15:0] mx,
                                  logic signed [47:0] sm);
    in_item_t it;
    it.key_word  = w;
    it.key_last  = l;
    it.add_count = c;
    it.add_min   = mn;
    it.add_max   = mx;
    it.add_sum   = sm;
    return it;
  endfunction

  function automatic out_item_t mko(logic [9:0] idx, logic nw, logic [31:0] c,
                                    logic signed [15:0] mn, logic signed [15:0] mx,
                                    logic signed [47:0] sm);
    out_item_t o;
    o.entry_index = idx;
    o.is_new      = nw;
    o.dropped     = 1'b0;
    o.total_count = c;
    o.min_tenths  = mn;
    o.max_tenths  = mx;
    o.sum_tenths  = sm;
    return o;
  endfunction

  // random aggregate on a word: mostly raw samples, some partials, some extremes
  function automatic in_item_t rand_agg(logic [63:0] w);
    in_item_t           it;
    logic signed [15:0] v;
    logic [31:0]        x;
    int                 r;
    r = $urandom_range(0, 99);
    v = 16'($urandom);
    x = $urandom;
    it = mk(w, 1'b1, 32'd1, v, v, {{32{v[15]}}, v});
    if (r >= 60 && r < 90) begin
      it.add_count = $urandom_range(1, 1000);
      it.add_min   = 16'($urandom);
      it.add_max   = 16'($urandom);
      it.add_sum   = {{16{x[31]}}, x};
    end else if (r >= 90) begin
      it.add_count = $urandom;
      it.add_min   = 16'($urandom);
      it.add_max   = 16'($urandom);
      it.add_sum   = 48'({$urandom, $urandom});
      if (r >= 97) it.add_sum = (r[0]) ? SumMax : SumMin;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t ex);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_typed <= typed;
    row_exp   <= ex;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_key(logic [KW-1:0][63:0] k, int len, int extra);
    for (int i = 0; i < len + extra - 1; i++)
      send_item(mk((i < KW) ? k[i] : 64'({$urandom, $urandom}), 1'b0, 0, 0, 0, 0),
                1'b0, '0);
    send_item(rand_agg((len + extra - 1 < KW) ? k[len + extra - 1] :
                       64'({$urandom, $urandom})), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_totals.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t ex;
  } dir_row_t;

  initial begin
    dir_row_t            rows[$];
    logic [KW-1:0][63:0] pool_key [POOL];
    int                  pool_len [POOL];
    logic [KW-1:0][63:0] k;
    int                  p, mode, len, nrec, ok;
    logic [63:0]         one;

    one = '1;
    rows.push_back('{mk(64'h61, 1, 1, 5, 5, 5), 1, mko(0, 1, 1, 5, 5, 5)});
    rows.push_back('{mk(64'h61, 1, 1, -3, -3, -3), 1, mko(0, 0, 2, -3, 5, 2)});
    // extremes of every aggregate field on a new key
    rows.push_back('{mk(one, 1, '1, -32768, 32767, SumMax), 1,
                     mko(1, 1, '1, -32768, 32767, SumMax)});
    // count and sum saturate upward
    rows.push_back('{mk(one, 1, 5, 0, 0, 1), 1, mko(1, 0, '1, -32768, 32767, SumMax)});
    // zero count is taken as given
    rows.push_back('{mk(one, 1, 0, 0, 0, SumMin), 1, mko(1, 0, '1, -32768, 32767, -1)});
    // sum saturates downward
    rows.push_back('{mk(one, 1, 1, 0, 0, SumMin), 1,
                     mko(1, 0, '1, -32768, 32767, SumMin)});
    rows.push_back('{mk(64'h6f6c, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(64'h2, 1, 1, 100, 100, 100), 0, '0});
    // embedded zero byte, min above max on a new entry and on a merge
    rows.push_back('{mk(64'h0000_0062_0000_0061, 1, 3, 40, -40, 0), 0, '0});
    rows.push_back('{mk(64'h0000_0062_0000_0061, 1, 2, 50, -50, 7), 0, '0});
    // overlong key: the fourteenth word carries only the aggregate
    for (int i = 0; i < KW; i++)
      rows.push_back('{mk(64'h100 + i, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(64'hDEAD, 1, 1, 9, 9, 9), 0, '0});

    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = '0;
      pool_len[i] = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 2)
                                                 : $urandom_range(1, KW);
      for (int j = 0; j < pool_len[i]; j++) begin
        pool_key[i][j] = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) pool_key[i][j][63:32] = '0;
      end
    end

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].ex);

    nrec = 0;
    while (words_sent < RAND_WORDS) begin
      mode = $urandom_range(0, 99);
      p = $urandom_range(0, POOL - 1);
      if (mode < 70) begin
        send_key(pool_key[p], pool_len[p], 0);
      end else if (mode < 80) begin
        // trailing zero words still match the padded key
        send_key(pool_key[p], pool_len[p], $urandom_range(0, KW - pool_len[p]));
      end else if (mode < 88) begin
        send_key(pool_key[p], KW, $urandom_range(1, 3));
      end else begin
        len = $urandom_range(1, 15);
        for (int j = 0; j < KW; j++) k[j] = {$urandom, $urandom};
        send_key(k, len, 0);
      end
      nrec++;
      if (nrec == 20) wait_drained();
      if (words_sent > RAND_WORDS - 100) quiet = 1'b1;
    end

    // fill the rest of the table, then records that find it full
    quiet = 1'b1;
    while (used < TD) begin
      send_item(rand_agg(64'hF11E_0000_0000_0000 | 64'(used)), 1'b0, '0);
      @(posedge clk);
    end
    for (int i = 0; i < 3; i++) send_item(rand_agg(64'hF11F_0000_0000_0000 | i), 1'b0, '0);
    send_item(rand_agg(64'h61), 1'b0, '0);
    send_key(pool_key[0], pool_len[0], 0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    ok = (mismatch_cnt == 0) && (pending_totals.size() == 0);
    $display("%0d words in %0d records: %0d new entries, %0d merges, %0d dropped",
             words_sent, n_records, n_new, n_merge, n_drop);
    $display("table filled to %0d entries, %0d mismatches", used, mismatch_cnt);
    if (ok) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
